// ===== design/pita_pkg.sv =====
package pita_pkg;

    // Format selector codes
    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    // Default saturation point of the field width
    localparam int MAX_WIDTH_DEF = 63;

    // Digit count limits for each radix
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);

    // Reciprocal of ten: floor(v * RECIP10 / 2**RECIP_SHIFT) == v / 10 for any 32-bit v
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // ASCII bases for digits
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LC_A = 8'h61;

    // Control word from the sequencer to the digit unit
    typedef struct packed {
        logic mul_en;
        logic hex;
    } unit_ctrl_t;

    // Map a digit value to its lower-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = ASCII_ZERO + {4'd0, d};
        end
        else
        begin
            ch = ASCII_LC_A + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ===== design/pita_digit_unit.sv =====
module pita_digit_unit
    import pita_pkg::*;
(
    input  logic             clk,
    input  unit_ctrl_t       ctrl,
    input  logic [31:0]      val,
    output logic [31:0]      quot,
    output logic [3:0]       digit
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [31:0] dec_quot;
    logic [31:0] times_ten;
    logic [31:0] dec_rem;

    // Reciprocal product for the decimal step, registered before use.
    assign prod_next = {32'd0, val} * {32'd0, RECIP10};

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Quotient by ten and remainder by shift-and-add back-multiplication.
    assign dec_quot  = 32'(prod_reg >> RECIP_SHIFT);
    assign times_ten = (dec_quot << 3) + (dec_quot << 1);
    assign dec_rem   = val - times_ten;

    // Select the radix: hexadecimal is a plain nibble shift.
    assign quot  = ctrl.hex ? (val >> 4) : dec_quot;
    assign digit = ctrl.hex ? val[3:0] : dec_rem[3:0];

endmodule

// ===== design/pita_ctrl.sv =====
module pita_ctrl
    import pita_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    input  logic [31:0]      value,
    input  logic [5:0]       field_width,
    input  logic [7:0]       pad_char,
    input  logic [31:0]      quot,
    input  logic [3:0]       digit,
    output unit_ctrl_t       unit_ctrl,
    output logic [31:0]      val_out,
    output logic             busy,
    output logic             strobe,
    output logic [7:0]       out_char,
    output logic             last
);

    localparam logic [5:0] WIDTH_SAT = 6'(MAX_WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [NDIG_W-1:0] ndig_reg;
    logic [NDIG_W-1:0] ndig_next;
    logic [5:0]        pad_cnt_reg;
    logic [5:0]        pad_cnt_next;
    logic [31:0]       val_reg;
    logic [31:0]       val_next;
    logic              hex_reg;
    logic [5:0]        width_reg;
    logic [7:0]        pad_reg;
    logic [3:0]        stack_reg [DEC_DIGITS];
    logic [NDIG_W-1:0] ndig_inc;
    logic [NDIG_W-1:0] ndig_limit;
    logic [5:0]        ndig_wide;
    logic              more;
    logic              push;
    logic              pop;
    logic              accept;

    assign accept     = start && (state_reg == S_IDLE);
    assign ndig_inc   = ndig_reg + NDIG_W'(1);
    assign ndig_limit = hex_reg ? NDIG_W'(HEX_DIGITS) : NDIG_W'(DEC_DIGITS);
    assign ndig_wide  = 6'(ndig_inc);
    assign more       = (quot != 32'd0) && (ndig_inc != ndig_limit);
    assign push       = (state_reg == S_STEP);
    assign pop        = (state_reg == S_DIG);

    // Sequencer: extract digits least significant first, then pad, then emit.
    always_comb
    begin
        state_next   = state_reg;
        ndig_next    = ndig_reg;
        pad_cnt_next = pad_cnt_reg;
        val_next     = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ndig_next  = '0;
                    val_next   = value;
                    state_next = (command == CMD_HEX) ? S_STEP : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                ndig_next = ndig_inc;
                val_next  = quot;
                if (more)
                begin
                    state_next = hex_reg ? S_STEP : S_MUL;
                end
                else if (width_reg > ndig_wide)
                begin
                    pad_cnt_next = width_reg - ndig_wide;
                    state_next   = S_PAD;
                end
                else
                begin
                    state_next = S_DIG;
                end
            end
            S_PAD:
            begin
                pad_cnt_next = pad_cnt_reg - 6'd1;
                if (pad_cnt_reg == 6'd1)
                begin
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                ndig_next = ndig_reg - NDIG_W'(1);
                if (ndig_reg == NDIG_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ndig_reg    <= '0;
            pad_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ndig_reg    <= ndig_next;
            pad_cnt_reg <= pad_cnt_next;
        end
    end

    // Item payload, captured when the command is taken.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (accept)
        begin
            hex_reg   <= command;
            width_reg <= (field_width > WIDTH_SAT) ? WIDTH_SAT : field_width;
            pad_reg   <= pad_char;
        end
    end

    // Digit stack: the newest, most significant digit sits at the top.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= digit;
            for (int i = 1; i < DEC_DIGITS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < DEC_DIGITS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    // Shared unit control and the current value word fed to the unit.
    assign unit_ctrl.mul_en = (state_reg == S_MUL);
    assign unit_ctrl.hex    = hex_reg;
    assign val_out          = val_reg;

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = (state_reg == S_PAD) || (state_reg == S_DIG);
    assign out_char = (state_reg == S_PAD) ? pad_reg : digit_char(stack_reg[0]);
    assign last     = (state_reg == S_DIG) && (ndig_reg == NDIG_W'(1));

    // A taken command makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("command taken but block not busy");

    // The final character of a run returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n) strobe && last |=> !busy)
        else $error("block still busy after final character");

    // Characters only leave the block while it is busy with an item.
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> busy)
        else $error("character word emitted while idle");

    // A pad character is never followed by an extraction step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |=> (state_reg == S_PAD) || (state_reg == S_DIG))
        else $error("padding not followed by digits");

endmodule

// ===== design/padded_integer_to_ascii.sv =====
// Converts a 32-bit unsigned value to ASCII, decimal or lower-case hexadecimal, with left
// padding to a minimum field width (saturated at MAX_WIDTH), emitting one character word
// per cycle with last on the final digit. A command is taken when start is high and busy
// is low; busy then stays high until the cycle after the last character. Digits come from
// one shared divide-by-radix unit: a decimal digit takes a reciprocal multiply, then a
// remainder step, and a hexadecimal digit only the step. Characters are driven with strobe
// for exactly one cycle each and cannot be held off, so the receiver must take every word
// as it comes.
module padded_integer_to_ascii
    import pita_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] value,
    input  logic [5:0]  field_width,
    input  logic [7:0]  pad_char,
    output logic        strobe,
    output logic [7:0]  out_char,
    output logic        last
);

    unit_ctrl_t  unit_ctrl;
    logic [31:0] val_cur;
    logic [31:0] quot;
    logic [3:0]  digit;

    // Shared digit extraction unit.
    pita_digit_unit u_digit_unit (
        .clk   (clk),
        .ctrl  (unit_ctrl),
        .val   (val_cur),
        .quot  (quot),
        .digit (digit)
    );

    // Sequencer, digit stack and character output.
    pita_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .value       (value),
        .field_width (field_width),
        .pad_char    (pad_char),
        .quot        (quot),
        .digit       (digit),
        .unit_ctrl   (unit_ctrl),
        .val_out     (val_cur),
        .busy        (busy),
        .strobe      (strobe),
        .out_char    (out_char),
        .last        (last)
    );

endmodule
